// ===== sv/fad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fad_pkg
// Shared widths, codes and types of the flow alert detector.
// ----------------------------------------------------------------------------
package fad_pkg;

    localparam int SAMPLE_W = 24;
    localparam int BAD_W    = 16;
    localparam int RUN_W    = 16;
    localparam int IDLE_W   = 23;
    localparam int ALERT_W  = 3;
    localparam int LEVEL_W  = 16;
    localparam int CFG_IDX_W = 3;

    // Divider: signed numerator, unsigned divisor, 24-bit signed quotient.
    localparam int DIV_NUM_W = 41;
    localparam int DIV_MAG_W = DIV_NUM_W - 1;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam logic [ALERT_W-1:0] ALERT_NONE     = 3'd0;
    localparam logic [ALERT_W-1:0] ALERT_BURST    = 3'd1;
    localparam logic [ALERT_W-1:0] ALERT_IDLE_ON  = 3'd2;
    localparam logic [ALERT_W-1:0] ALERT_IDLE_OFF = 3'd3;
    localparam logic [ALERT_W-1:0] ALERT_LEAK_ON  = 3'd4;
    localparam logic [ALERT_W-1:0] ALERT_LEAK_OFF = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_RUNS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_RUNS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_RUNS   = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : fad_pkg
`default_nettype wire

// ===== sv/fad_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fad_div
// Restoring serial divider, one quotient bit per cycle, truncating toward
// zero. Shared by the window average and the running leak mean.
// ----------------------------------------------------------------------------
module fad_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [fad_pkg::DIV_NUM_W-1:0] numer,
    input  wire logic        [fad_pkg::DIV_DEN_W-1:0] denom,
    output fad_pkg::div_status_t                      status,
    output logic signed      [fad_pkg::SAMPLE_W-1:0]  quotient
);
    import fad_pkg::*;

    logic [DIV_MAG_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    logic [DIV_NUM_W-1:0] numer_abs;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign numer_abs = numer[DIV_NUM_W-1] ? (~numer + 1'b1) : numer;
    assign trial     = {rem_reg, quo_reg[DIV_MAG_W-1]};
    assign fits      = trial >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = numer_abs[DIV_MAG_W-1:0];
            rem_next = '0;
            den_next = denom;
            neg_next = numer[DIV_NUM_W-1];
            cnt_next = DIV_CNT_W'(DIV_MAG_W);
        end else if (cnt_reg != '0) begin
            // Shift in the next numerator bit and subtract where it fits.
            if (fits) begin
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[DIV_DEN_W-1:0];
            end
            quo_next  = {quo_reg[DIV_MAG_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = neg_reg ? -$signed(quo_reg[SAMPLE_W-1:0])
                                 : $signed(quo_reg[SAMPLE_W-1:0]);

endmodule : fad_div
`default_nettype wire

// ===== sv/flow_alert_detector.sv =====
`default_nettype none
// Sequence: a sample that leaves its window open goes to S_OUT, which loads its word
// once the output is free; a completed window runs S_AVG, then S_CHECK when the checks
// run, and S_MUL, S_ADD, S_MEAN and S_LEAK when the leak check updates the running mean
// (two 40-step divisions), before S_OUT. One sample at a time: a new one is accepted in
// the cycle after the previous word is loaded.
// Reset (aresetn low, synchronous) clears all run state and loads the defaults.
// ----------------------------------------------------------------------------
// flow_alert_detector
// Windowed flow averaging with burst, idle and leak run-length alerts,
// sequenced around one shared serial divider.
// ----------------------------------------------------------------------------
module flow_alert_detector #(
    parameter int WINDOW = 2
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // flow_sample [23:0], bad_readings [39:24]
    input  wire logic [fad_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // window_done [0], window_average [24:1], alert_code [27:25],
    // leak_level [43:28], zero [47:44]
    output logic [fad_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fad_pkg::SAMPLE_W-1:0]       cfg_data
);
    import fad_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int FILL_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PROD_W = SAMPLE_W + RUN_W + 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_AVG   = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ADD   = 8'b0001_0000,
        S_MEAN  = 8'b0010_0000,
        S_LEAK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    function automatic logic [RUN_W-1:0] inc_sat(input logic [RUN_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] burst_limit_reg, burst_limit_next;
    logic        [RUN_W-1:0]    burst_runs_reg, burst_runs_next;
    logic        [IDLE_W-1:0]   idle_limit_reg, idle_limit_next;
    logic        [RUN_W-1:0]    idle_runs_reg, idle_runs_next;
    logic signed [SAMPLE_W-1:0] leak_limit_reg, leak_limit_next;
    logic        [RUN_W-1:0]    leak_runs_reg, leak_runs_next;

    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic        [FILL_W-1:0]   fill_reg, fill_next;
    logic        [RUN_W-1:0]    burst_cnt_reg, burst_cnt_next;
    logic        [RUN_W-1:0]    idle_cnt_reg, idle_cnt_next;
    logic                       idle_on_reg, idle_on_next;
    logic        [RUN_W-1:0]    leak_cnt_reg, leak_cnt_next;
    logic signed [SAMPLE_W-1:0] mean_reg, mean_next;
    logic signed [LEVEL_W-1:0]  level_reg, level_next;
    logic                       go_reg, go_next;
    logic                       m_valid_reg, m_valid_next;

    logic signed [SAMPLE_W-1:0]  avg_reg, avg_next;
    logic        [ALERT_W-1:0]   alert_reg, alert_next;
    logic                        done_reg, done_next;
    logic                        bad_ok_reg, bad_ok_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [DIV_NUM_W-1:0] num_reg, num_next;
    logic [OUT_DATA_W-1:0]       m_data_reg, m_data_next;

    logic signed [SAMPLE_W-1:0] sample;
    logic        [BAD_W-1:0]    bad;
    logic signed [SUM_W-1:0]    sum_new;
    logic                       last_of_window;
    logic signed [SAMPLE_W:0]   avg_wide, idle_lim_wide;
    logic                       idle_hit;
    logic        [RUN_W-1:0]    burst_run, idle_run;
    logic signed [SAMPLE_W-1:0] mean_adj;
    logic        [DIV_DEN_W-1:0] div_den;
    div_status_t                div_st;
    logic signed [SAMPLE_W-1:0] div_quo;

    assign sample         = $signed(s_tdata[SAMPLE_W-1:0]);
    assign bad            = s_tdata[SAMPLE_W +: BAD_W];
    assign sum_new        = sum_reg + SUM_W'(sample);
    assign last_of_window = (fill_reg == FILL_W'(WINDOW - 1));

    assign avg_wide      = (SAMPLE_W + 1)'(avg_reg);
    assign idle_lim_wide = $signed({2'b00, idle_limit_reg});
    assign idle_hit      = (avg_wide < idle_lim_wide) && (avg_wide > -idle_lim_wide);
    assign burst_run     = (avg_reg >= burst_limit_reg) ? inc_sat(burst_cnt_reg) : '0;
    assign idle_run      = idle_hit ? inc_sat(idle_cnt_reg) : '0;
    // Integer part truncated toward zero: bias negative means before the shift.
    assign mean_adj      = mean_reg + (mean_reg[SAMPLE_W-1] ? SAMPLE_W'(255) : '0);

    // The divider takes the window length for the average and the leak run
    // length for the running mean; it latches the divisor when it starts.
    assign div_den = (state_reg == S_AVG) ? DIV_DEN_W'(WINDOW) : leak_cnt_reg;

    fad_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (go_reg),
        .numer    (num_reg),
        .denom    (div_den),
        .status   (div_st),
        .quotient (div_quo)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        state_next       = state_reg;
        burst_limit_next = burst_limit_reg;
        burst_runs_next  = burst_runs_reg;
        idle_limit_next  = idle_limit_reg;
        idle_runs_next   = idle_runs_reg;
        leak_limit_next  = leak_limit_reg;
        leak_runs_next   = leak_runs_reg;
        sum_next         = sum_reg;
        fill_next        = fill_reg;
        burst_cnt_next   = burst_cnt_reg;
        idle_cnt_next    = idle_cnt_reg;
        idle_on_next     = idle_on_reg;
        leak_cnt_next    = leak_cnt_reg;
        mean_next        = mean_reg;
        level_next       = level_reg;
        go_next          = 1'b0;
        m_valid_next     = m_valid_reg;
        avg_next         = avg_reg;
        alert_next       = alert_reg;
        done_next        = done_reg;
        bad_ok_next      = bad_ok_reg;
        prod_next        = prod_reg;
        num_next         = num_reg;
        m_data_next      = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BURST_LIMIT: burst_limit_next = $signed(cfg_data);
                REG_BURST_RUNS:  burst_runs_next  = cfg_data[RUN_W-1:0];
                REG_IDLE_LIMIT:  idle_limit_next  = cfg_data[IDLE_W-1:0];
                REG_IDLE_RUNS:   idle_runs_next   = cfg_data[RUN_W-1:0];
                REG_LEAK_LIMIT:  leak_limit_next  = $signed(cfg_data);
                REG_LEAK_RUNS:   leak_runs_next   = cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    avg_next   = '0;
                    alert_next = ALERT_NONE;
                    if (last_of_window) begin
                        sum_next    = '0;
                        fill_next   = '0;
                        done_next   = 1'b1;
                        bad_ok_next = (bad < BAD_W'(WINDOW));
                        num_next    = DIV_NUM_W'(sum_new);
                        go_next     = 1'b1;
                        state_next  = S_AVG;
                    end else begin
                        sum_next   = sum_new;
                        fill_next  = fill_reg + 1'b1;
                        done_next  = 1'b0;
                        state_next = S_OUT;
                    end
                end
            end
            S_AVG: begin
                // The window average is the quotient of the window sum.
                if (div_st.done) begin
                    avg_next   = div_quo;
                    state_next = bad_ok_reg ? S_CHECK : S_OUT;
                end
            end
            S_CHECK: begin
                priority if (burst_run >= burst_runs_reg) begin
                    burst_cnt_next = '0;
                    alert_next     = ALERT_BURST;
                    state_next     = S_OUT;
                end else if (!idle_hit && idle_on_reg) begin
                    burst_cnt_next = burst_run;
                    idle_cnt_next  = '0;
                    idle_on_next   = 1'b0;
                    alert_next     = ALERT_IDLE_OFF;
                    state_next     = S_OUT;
                end else if (idle_run >= idle_runs_reg) begin
                    burst_cnt_next = burst_run;
                    idle_cnt_next  = '0;
                    idle_on_next   = 1'b1;
                    alert_next     = ALERT_IDLE_ON;
                    state_next     = S_OUT;
                end else if (avg_reg >= leak_limit_reg) begin
                    burst_cnt_next = burst_run;
                    idle_cnt_next  = idle_run;
                    leak_cnt_next  = inc_sat(leak_cnt_reg);
                    state_next     = S_MUL;
                end else begin
                    burst_cnt_next = burst_run;
                    idle_cnt_next  = idle_run;
                    leak_cnt_next  = '0;
                    mean_next      = '0;
                    state_next     = S_OUT;
                    if (level_reg != '0) begin
                        level_next = '0;
                        alert_next = ALERT_LEAK_OFF;
                    end else if (leak_runs_reg == '0) begin
                        alert_next = ALERT_LEAK_ON;
                    end
                end
            end
            S_MUL: begin
                prod_next  = mean_reg * $signed({1'b0, leak_cnt_reg - 1'b1});
                state_next = S_ADD;
            end
            S_ADD: begin
                num_next   = prod_reg + DIV_NUM_W'(avg_reg);
                go_next    = 1'b1;
                state_next = S_MEAN;
            end
            S_MEAN: begin
                if (div_st.done) begin
                    mean_next  = div_quo;
                    state_next = S_LEAK;
                end
            end
            S_LEAK: begin
                if (leak_cnt_reg >= leak_runs_reg) begin
                    leak_cnt_next = '0;
                    level_next    = mean_adj[SAMPLE_W-1:8];
                    alert_next    = ALERT_LEAK_ON;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, level_reg, alert_reg, avg_reg, done_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            burst_limit_reg <= SAMPLE_W'(8388607);
            burst_runs_reg  <= RUN_W'(3);
            idle_limit_reg  <= IDLE_W'(256);
            idle_runs_reg   <= RUN_W'(100);
            leak_limit_reg  <= SAMPLE_W'(512);
            leak_runs_reg   <= RUN_W'(100);
            sum_reg         <= '0;
            fill_reg        <= '0;
            burst_cnt_reg   <= '0;
            idle_cnt_reg    <= '0;
            idle_on_reg     <= 1'b0;
            leak_cnt_reg    <= '0;
            mean_reg        <= '0;
            level_reg       <= '0;
            go_reg          <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            burst_limit_reg <= burst_limit_next;
            burst_runs_reg  <= burst_runs_next;
            idle_limit_reg  <= idle_limit_next;
            idle_runs_reg   <= idle_runs_next;
            leak_limit_reg  <= leak_limit_next;
            leak_runs_reg   <= leak_runs_next;
            sum_reg         <= sum_next;
            fill_reg        <= fill_next;
            burst_cnt_reg   <= burst_cnt_next;
            idle_cnt_reg    <= idle_cnt_next;
            idle_on_reg     <= idle_on_next;
            leak_cnt_reg    <= leak_cnt_next;
            mean_reg        <= mean_next;
            level_reg       <= level_next;
            go_reg          <= go_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg    <= avg_next;
        alert_reg  <= alert_next;
        done_reg   <= done_next;
        bad_ok_reg <= bad_ok_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        m_data_reg <= m_data_next;
    end

    // The sequencer must never sit in a check state or in S_IDLE while a division runs.
    a_no_check_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK || state_reg == S_LEAK || state_reg == S_IDLE)
            |-> !div_st.busy)
        else $error("check state entered while the divider is busy");

    // A word without a completed window carries neither an average nor an alert.
    a_no_window_no_alert: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[27:1] == '0))
        else $error("alert or average reported without a completed window");

    // A leak-off alert always leaves the stored level cleared.
    a_leak_off_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && alert_reg == ALERT_LEAK_OFF) |-> (level_reg == '0))
        else $error("leak-off alert with a stored leak level");

    // A division is started only while the sequencer is in S_AVG or S_MEAN.
    a_div_start_source: assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> (state_reg == S_AVG || state_reg == S_MEAN))
        else $error("divider started outside the average or mean step");

endmodule : flow_alert_detector
`default_nettype wire
